[rtl/prm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prm_pkg
// Shared constants, operation and status codes, and the command and status
// bundles between the range map controller and its datapath.
// ----------------------------------------------------------------------------
package prm_pkg;

    // List depths and page size
    localparam int MAX_BANKS      = 8;
    localparam int MAX_EXCLUSIONS = 16;
    localparam int MAX_SEGMENTS   = 16;
    localparam int PAGE_SHIFT     = 12;

    localparam logic [63:0] PAGE_MASK = 64'((65'd1 << PAGE_SHIFT) - 65'd1);

    // Index and count widths
    localparam int BANK_IW = ($clog2(MAX_BANKS) > 0) ? $clog2(MAX_BANKS) : 1;
    localparam int EXCL_IW = ($clog2(MAX_EXCLUSIONS) > 0) ? $clog2(MAX_EXCLUSIONS) : 1;
    localparam int SEG_IW  = ($clog2(MAX_SEGMENTS) > 0) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int BANK_CW = $clog2(MAX_BANKS + 1);
    localparam int EXCL_CW = $clog2(MAX_EXCLUSIONS + 1);
    localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int LCW_A   = (BANK_CW > EXCL_CW) ? BANK_CW : EXCL_CW;
    localparam int LCW     = (LCW_A > SEG_CW) ? LCW_A : SEG_CW;

    // Operation codes
    localparam logic [2:0] OP_ADD_BANK = 3'd0;
    localparam logic [2:0] OP_ADD_EXCL = 3'd1;
    localparam logic [2:0] OP_QUERY    = 3'd2;
    localparam logic [2:0] OP_BUILD    = 3'd3;
    localparam logic [2:0] OP_LOOKUP   = 3'd4;
    localparam logic [2:0] OP_SPAN     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_BANKS = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    // Result kinds
    localparam logic [1:0] EK_ONE      = 2'd0;
    localparam logic [1:0] EK_SEG_MID  = 2'd1;
    localparam logic [1:0] EK_SEG_TAIL = 2'd2;
    localparam logic [1:0] EK_TOTAL    = 2'd3;

    // Read index sources
    localparam logic [2:0] RS_I    = 3'd0;
    localparam logic [2:0] RS_J    = 3'd1;
    localparam logic [2:0] RS_JM1  = 3'd2;
    localparam logic [2:0] RS_B    = 3'd3;
    localparam logic [2:0] RS_X    = 3'd4;
    localparam logic [2:0] RS_LAST = 3'd5;

    typedef struct packed {
        logic       load;
        logic       round;
        logic       inc_i;
        logic       merge;
        logic       absorb_step;
        logic       absorb_end;
        logic       shdn_step;
        logic       shdn_end;
        logic       shup_init;
        logic       shup_step;
        logic       shup_end;
        logic       seg_clear;
        logic       bank_load;
        logic       inc_x;
        logic       set_s_xe;
        logic       set_e_xs;
        logic       inc_b;
        logic       set_lookup;
        logic       set_span;
        logic       emit;
        logic [2:0] rd_src;
        logic [1:0] emit_kind;
        logic [1:0] status;
        logic       hit;
    } cmd_t;

    typedef struct packed {
        logic round_ok;
        logic i_done;
        logic merge;
        logic st_below;
        logic list_full;
        logic j_done;
        logic absorb_stop;
        logic n_zero;
        logic shup_done;
        logic q_hit;
        logic l_done;
        logic l_hit;
        logic bank_empty;
        logic bank_done;
        logic x_done;
        logic xe_le_s;
        logic xs_ge_e;
        logic xs_le_s;
        logic xe_ge_e;
        logic seg_full;
        logic tail_empty;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[rtl/physical_range_map_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// physical_range_map_top
// Sorted, coalesced lists of RAM banks and exclusions, with overlap query,
// segment build (banks minus exclusions), segment lookup and bank span.
// ----------------------------------------------------------------------------
//  Channel  Ports                                           Direction
//  s_       s_valid s_ready s_op s_addr s_size              input items
//  m_       m_valid m_ready m_status m_hit m_seg_index      result items
//           m_range_start m_range_end m_total_bytes m_last
//
//  One operation at a time; s_ready is high only while the sequencer idles.
//  An insert emptied by rounding goes straight to its result; query and lookup
//  stop at the first hit and walk the whole list on a miss; a build walks each
//  bank in turn together with the exclusions that it reaches.
//  Reset empties all three lists; no clearing pass is needed.
//  A stalled m_ready holds the result and pauses a build at its next transfer.
// ----------------------------------------------------------------------------
module physical_range_map_top
    import prm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [63:0] s_addr,
    input  wire logic [63:0] s_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_hit,
    output logic [4:0]       m_seg_index,
    output logic [63:0]      m_range_start,
    output logic [63:0]      m_range_end,
    output logic [63:0]      m_total_bytes,
    output logic             m_last
);

    cmd_t cmd;
    sts_t sts;

    prm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    prm_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_op          (s_op),
        .s_addr        (s_addr),
        .s_size        (s_size),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_hit         (m_hit),
        .m_seg_index   (m_seg_index),
        .m_range_start (m_range_start),
        .m_range_end   (m_range_end),
        .m_total_bytes (m_total_bytes),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

[rtl/prm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prm_ctrl
// Sequencer for the range map: takes one operation at a time, steps the
// datapath through list walks, shifts and the build, and issues results.
// ----------------------------------------------------------------------------
module prm_ctrl
    import prm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [2:0] s_op,
    output logic            s_ready,
    output cmd_t            cmd,
    input  wire sts_t       sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_ISCAN  = 4'd2;
    localparam logic [3:0] S_ABSORB = 4'd3;
    localparam logic [3:0] S_SHDN   = 4'd4;
    localparam logic [3:0] S_ICHK   = 4'd5;
    localparam logic [3:0] S_SHUP   = 4'd6;
    localparam logic [3:0] S_QSCAN  = 4'd7;
    localparam logic [3:0] S_LSCAN  = 4'd8;
    localparam logic [3:0] S_SPAN   = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_BINIT  = 4'd11;
    localparam logic [3:0] S_BBANK  = 4'd12;
    localparam logic [3:0] S_BEXCL  = 4'd13;
    localparam logic [3:0] S_BTAIL  = 4'd14;
    localparam logic [3:0] S_TOTAL  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       res_hit_reg, res_hit_next;

    // Hold state and pending result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_hit_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
        end
    end

    // Decide next state and commands
    always_comb begin
        cmd             = '0;
        cmd.rd_src      = RS_I;
        cmd.status      = res_status_reg;
        cmd.hit         = res_hit_reg;
        s_ready         = 1'b0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load        = 1'b1;
                    res_status_next = ST_OK;
                    res_hit_next    = 1'b0;
                    case (s_op)
                        OP_ADD_BANK: state_next = S_PREP;
                        OP_ADD_EXCL: state_next = S_PREP;
                        OP_QUERY:    state_next = S_QSCAN;
                        OP_BUILD:    state_next = S_BINIT;
                        OP_LOOKUP:   state_next = S_LSCAN;
                        OP_SPAN:     state_next = S_SPAN;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_PREP: begin
                if (sts.round_ok) begin
                    cmd.round  = 1'b1;
                    state_next = S_ISCAN;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_ISCAN: begin
                if (sts.i_done) begin
                    state_next = S_ICHK;
                end else if (sts.merge) begin
                    cmd.merge  = 1'b1;
                    state_next = S_ABSORB;
                end else if (sts.st_below) begin
                    state_next = S_ICHK;
                end else begin
                    cmd.inc_i = 1'b1;
                end
            end
            S_ABSORB: begin
                cmd.rd_src = RS_J;
                if (sts.j_done || sts.absorb_stop) begin
                    cmd.absorb_end = 1'b1;
                    state_next     = sts.n_zero ? S_EMIT : S_SHDN;
                end else begin
                    cmd.absorb_step = 1'b1;
                end
            end
            S_SHDN: begin
                cmd.rd_src = RS_J;
                if (sts.j_done) begin
                    cmd.shdn_end = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.shdn_step = 1'b1;
                end
            end
            S_ICHK: begin
                if (sts.list_full) begin
                    res_status_next = ST_FULL;
                    state_next      = S_EMIT;
                end else begin
                    cmd.shup_init = 1'b1;
                    state_next    = S_SHUP;
                end
            end
            S_SHUP: begin
                cmd.rd_src = RS_JM1;
                if (sts.shup_done) begin
                    cmd.shup_end = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.shup_step = 1'b1;
                end
            end
            S_QSCAN: begin
                if (sts.i_done) begin
                    state_next = S_EMIT;
                end else if (sts.q_hit) begin
                    res_hit_next = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.inc_i = 1'b1;
                end
            end
            S_LSCAN: begin
                if (sts.l_done) begin
                    state_next = S_EMIT;
                end else if (sts.l_hit) begin
                    cmd.set_lookup = 1'b1;
                    res_hit_next   = 1'b1;
                    state_next     = S_EMIT;
                end else begin
                    cmd.inc_i = 1'b1;
                end
            end
            S_SPAN: begin
                cmd.rd_src = RS_LAST;
                if (sts.bank_empty) begin
                    res_status_next = ST_NO_BANKS;
                end else begin
                    cmd.set_span = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_ONE;
                    state_next    = S_IDLE;
                end
            end
            S_BINIT: begin
                cmd.seg_clear = 1'b1;
                state_next    = S_BBANK;
            end
            S_BBANK: begin
                cmd.rd_src = RS_B;
                if (sts.bank_done) begin
                    state_next = S_TOTAL;
                end else begin
                    cmd.bank_load = 1'b1;
                    state_next    = S_BEXCL;
                end
            end
            S_BEXCL: begin
                cmd.rd_src = RS_X;
                if (sts.x_done) begin
                    state_next = S_BTAIL;
                end else if (sts.xe_le_s) begin
                    cmd.inc_x = 1'b1;
                end else if (sts.xs_ge_e) begin
                    state_next = S_BTAIL;
                end else if (sts.xs_le_s) begin
                    // Exclusion covers the bank start: move the start past it
                    cmd.set_s_xe = 1'b1;
                    if (sts.xe_ge_e) begin
                        state_next = S_BTAIL;
                    end else begin
                        cmd.inc_x = 1'b1;
                    end
                end else if (sts.xe_ge_e) begin
                    cmd.set_e_xs = 1'b1;
                    state_next   = S_BTAIL;
                end else if (sts.seg_full) begin
                    res_status_next = ST_TOO_MANY;
                    state_next      = S_TOTAL;
                end else if (sts.out_free) begin
                    // Exclusion splits the bank: issue the lower piece
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_SEG_MID;
                end
            end
            S_BTAIL: begin
                if (sts.tail_empty) begin
                    cmd.inc_b  = 1'b1;
                    state_next = S_BBANK;
                end else if (sts.seg_full) begin
                    res_status_next = ST_TOO_MANY;
                    state_next      = S_TOTAL;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_SEG_TAIL;
                    state_next    = S_BBANK;
                end
            end
            S_TOTAL: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_TOTAL;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/prm_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prm_dp
// Range map datapath: bank, exclusion and segment lists, walk counters,
// compares for the controller and the result output register.
// ----------------------------------------------------------------------------
module prm_dp
    import prm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [2:0]  s_op,
    input  wire logic [63:0] s_addr,
    input  wire logic [63:0] s_size,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic        m_ready,
    output logic             m_valid,
    output logic [1:0]       m_status,
    output logic             m_hit,
    output logic [4:0]       m_seg_index,
    output logic [63:0]      m_range_start,
    output logic [63:0]      m_range_end,
    output logic [63:0]      m_total_bytes,
    output logic             m_last
);

    // List storage, kept as start and wrapped end
    logic [63:0] bank_st_reg [MAX_BANKS];
    logic [63:0] bank_en_reg [MAX_BANKS];
    logic [63:0] excl_st_reg [MAX_EXCLUSIONS];
    logic [63:0] excl_en_reg [MAX_EXCLUSIONS];
    logic [63:0] seg_lo_reg  [MAX_SEGMENTS];
    logic [63:0] seg_hi_reg  [MAX_SEGMENTS];

    logic [BANK_CW-1:0] bank_cnt_reg;
    logic [EXCL_CW-1:0] excl_cnt_reg;
    logic [SEG_CW-1:0]  seg_cnt_reg;

    logic [63:0]        a_reg, e_reg, cur_end_reg, total_reg;
    logic [63:0]        res_lo_reg, res_hi_reg;
    logic [LCW-1:0]     res_idx_reg;
    logic               sel_reg;
    logic [LCW-1:0]     i_reg, j_reg, n_reg;
    logic [BANK_CW-1:0] b_reg;
    logic [EXCL_CW-1:0] x_reg;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic               m_hit_reg, m_last_reg;
    logic [4:0]         m_seg_index_reg;
    logic [63:0]        m_range_start_reg, m_range_end_reg, m_total_bytes_reg;

    logic [LCW-1:0] idx, sel_cnt, sel_max, wa;
    logic [63:0]    bank_rd_st, bank_rd_en, excl_rd_st, excl_rd_en;
    logic [63:0]    seg_rd_lo, seg_rd_hi, rd_st, rd_en;
    logic [63:0]    round_s, round_e, wst, wen;
    logic           we_st, we_en;

    // Select the read index for this step
    always_comb begin
        case (cmd.rd_src)
            RS_I:    idx = i_reg;
            RS_J:    idx = j_reg;
            RS_JM1:  idx = j_reg - LCW'(1);
            RS_B:    idx = LCW'(b_reg);
            RS_X:    idx = LCW'(x_reg);
            RS_LAST: idx = LCW'(bank_cnt_reg) - LCW'(1);
            default: idx = i_reg;
        endcase
    end

    assign bank_rd_st = bank_st_reg[idx[BANK_IW-1:0]];
    assign bank_rd_en = bank_en_reg[idx[BANK_IW-1:0]];
    assign excl_rd_st = excl_st_reg[idx[EXCL_IW-1:0]];
    assign excl_rd_en = excl_en_reg[idx[EXCL_IW-1:0]];
    assign seg_rd_lo  = seg_lo_reg[idx[SEG_IW-1:0]];
    assign seg_rd_hi  = seg_hi_reg[idx[SEG_IW-1:0]];
    assign rd_st      = sel_reg ? excl_rd_st : bank_rd_st;
    assign rd_en      = sel_reg ? excl_rd_en : bank_rd_en;
    assign sel_cnt    = sel_reg ? LCW'(excl_cnt_reg) : LCW'(bank_cnt_reg);
    assign sel_max    = sel_reg ? LCW'(MAX_EXCLUSIONS) : LCW'(MAX_BANKS);

    // Round banks inward and exclusions outward to whole pages
    always_comb begin
        if (sel_reg) begin
            round_s = a_reg & ~PAGE_MASK;
            round_e = (e_reg + PAGE_MASK) & ~PAGE_MASK;
        end else begin
            round_s = (a_reg + PAGE_MASK) & ~PAGE_MASK;
            round_e = e_reg & ~PAGE_MASK;
        end
    end

    // Status for the controller
    always_comb begin
        sts             = '0;
        sts.round_ok    = round_s < round_e;
        sts.i_done      = i_reg == sel_cnt;
        sts.merge       = (a_reg <= rd_en) && (e_reg >= rd_st);
        sts.st_below    = a_reg < rd_st;
        sts.list_full   = sel_cnt >= sel_max;
        sts.j_done      = j_reg == sel_cnt;
        sts.absorb_stop = rd_st > cur_end_reg;
        sts.n_zero      = j_reg == (i_reg + LCW'(1));
        sts.shup_done   = j_reg == i_reg;
        sts.q_hit       = (a_reg < rd_en) && (e_reg > rd_st);
        sts.l_done      = i_reg == LCW'(seg_cnt_reg);
        sts.l_hit       = (a_reg >= seg_rd_lo) && (a_reg < seg_rd_hi);
        sts.bank_empty  = bank_cnt_reg == '0;
        sts.bank_done   = b_reg == bank_cnt_reg;
        sts.x_done      = x_reg == excl_cnt_reg;
        sts.xe_le_s     = excl_rd_en <= a_reg;
        sts.xs_ge_e     = excl_rd_st >= e_reg;
        sts.xs_le_s     = excl_rd_st <= a_reg;
        sts.xe_ge_e     = excl_rd_en >= e_reg;
        sts.seg_full    = seg_cnt_reg >= SEG_CW'(MAX_SEGMENTS);
        sts.tail_empty  = a_reg >= e_reg;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    // List write port: merge, absorb, shift down, shift up, insert
    always_comb begin
        we_st = 1'b0;
        we_en = 1'b0;
        wa    = i_reg;
        wst   = rd_st;
        wen   = rd_en;
        if (cmd.merge) begin
            we_st = 1'b1;
            wst   = (a_reg < rd_st) ? a_reg : rd_st;
        end else if (cmd.absorb_end) begin
            we_en = 1'b1;
            wen   = cur_end_reg;
        end else if (cmd.shdn_step) begin
            we_st = 1'b1;
            we_en = 1'b1;
            wa    = j_reg - n_reg;
        end else if (cmd.shup_step) begin
            we_st = 1'b1;
            we_en = 1'b1;
            wa    = j_reg;
        end else if (cmd.shup_end) begin
            we_st = 1'b1;
            we_en = 1'b1;
            wst   = a_reg;
            wen   = e_reg;
        end
    end

    // Update list and segment storage
    always_ff @(posedge aclk) begin
        if (we_st && !sel_reg) bank_st_reg[wa[BANK_IW-1:0]] <= wst;
        if (we_en && !sel_reg) bank_en_reg[wa[BANK_IW-1:0]] <= wen;
        if (we_st && sel_reg)  excl_st_reg[wa[EXCL_IW-1:0]] <= wst;
        if (we_en && sel_reg)  excl_en_reg[wa[EXCL_IW-1:0]] <= wen;
        if (cmd.emit && (cmd.emit_kind == EK_SEG_MID || cmd.emit_kind == EK_SEG_TAIL)) begin
            seg_lo_reg[seg_cnt_reg[SEG_IW-1:0]] <= a_reg;
            seg_hi_reg[seg_cnt_reg[SEG_IW-1:0]] <=
                (cmd.emit_kind == EK_SEG_MID) ? excl_rd_st : e_reg;
        end
    end

    // Advance counts and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_cnt_reg <= '0;
            excl_cnt_reg <= '0;
            seg_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.shdn_end) begin
                if (sel_reg) excl_cnt_reg <= excl_cnt_reg - EXCL_CW'(n_reg);
                else         bank_cnt_reg <= bank_cnt_reg - BANK_CW'(n_reg);
            end else if (cmd.shup_end) begin
                if (sel_reg) excl_cnt_reg <= excl_cnt_reg + EXCL_CW'(1);
                else         bank_cnt_reg <= bank_cnt_reg + BANK_CW'(1);
            end
            if (cmd.seg_clear) begin
                seg_cnt_reg <= '0;
            end else if (cmd.emit && (cmd.emit_kind == EK_SEG_MID ||
                                      cmd.emit_kind == EK_SEG_TAIL)) begin
                seg_cnt_reg <= seg_cnt_reg + SEG_CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers for walks and the build
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg       <= s_addr;
            e_reg       <= s_addr + s_size;
            sel_reg     <= (s_op == OP_ADD_EXCL) || (s_op == OP_QUERY);
            i_reg       <= '0;
            res_idx_reg <= '0;
            res_lo_reg  <= '0;
            res_hi_reg  <= '0;
        end
        if (cmd.round) begin
            a_reg <= round_s;
            e_reg <= round_e;
        end
        if (cmd.inc_i) i_reg <= i_reg + LCW'(1);
        if (cmd.merge) begin
            cur_end_reg <= (e_reg > rd_en) ? e_reg : rd_en;
            j_reg       <= i_reg + LCW'(1);
        end
        if (cmd.absorb_step) begin
            if (rd_en > cur_end_reg) cur_end_reg <= rd_en;
            j_reg <= j_reg + LCW'(1);
        end
        if (cmd.absorb_end) n_reg <= j_reg - i_reg - LCW'(1);
        if (cmd.shdn_step)  j_reg <= j_reg + LCW'(1);
        if (cmd.shup_init)  j_reg <= sel_cnt;
        if (cmd.shup_step)  j_reg <= j_reg - LCW'(1);
        if (cmd.seg_clear) begin
            b_reg     <= '0;
            total_reg <= '0;
        end
        if (cmd.bank_load) begin
            a_reg <= bank_rd_st;
            e_reg <= bank_rd_en;
            x_reg <= '0;
        end
        if (cmd.set_s_xe) a_reg <= excl_rd_en;
        if (cmd.set_e_xs) e_reg <= excl_rd_st;
        if (cmd.inc_x)    x_reg <= x_reg + EXCL_CW'(1);
        if (cmd.inc_b)    b_reg <= b_reg + BANK_CW'(1);
        if (cmd.emit && cmd.emit_kind == EK_SEG_MID) begin
            total_reg <= total_reg + excl_rd_st - a_reg;
            a_reg     <= excl_rd_en;
            x_reg     <= x_reg + EXCL_CW'(1);
        end
        if (cmd.emit && cmd.emit_kind == EK_SEG_TAIL) begin
            total_reg <= total_reg + e_reg - a_reg;
            b_reg     <= b_reg + BANK_CW'(1);
        end
        if (cmd.set_lookup) begin
            res_idx_reg <= i_reg;
            res_lo_reg  <= seg_rd_lo;
            res_hi_reg  <= seg_rd_hi;
        end
        if (cmd.set_span) begin
            res_lo_reg <= bank_st_reg[0];
            res_hi_reg <= bank_rd_en;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            case (cmd.emit_kind)
                EK_ONE: begin
                    m_status_reg      <= cmd.status;
                    m_hit_reg         <= cmd.hit;
                    m_seg_index_reg   <= 5'(res_idx_reg);
                    m_range_start_reg <= res_lo_reg;
                    m_range_end_reg   <= res_hi_reg;
                    m_total_bytes_reg <= '0;
                    m_last_reg        <= 1'b1;
                end
                EK_SEG_MID, EK_SEG_TAIL: begin
                    m_status_reg      <= ST_OK;
                    m_hit_reg         <= 1'b0;
                    m_seg_index_reg   <= 5'(seg_cnt_reg);
                    m_range_start_reg <= a_reg;
                    m_range_end_reg   <= (cmd.emit_kind == EK_SEG_MID) ? excl_rd_st : e_reg;
                    m_total_bytes_reg <= '0;
                    m_last_reg        <= 1'b0;
                end
                default: begin
                    m_status_reg      <= cmd.status;
                    m_hit_reg         <= 1'b0;
                    m_seg_index_reg   <= 5'(seg_cnt_reg);
                    m_range_start_reg <= '0;
                    m_range_end_reg   <= '0;
                    m_total_bytes_reg <= total_reg;
                    m_last_reg        <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_hit         = m_hit_reg;
    assign m_seg_index   = m_seg_index_reg;
    assign m_range_start = m_range_start_reg;
    assign m_range_end   = m_range_end_reg;
    assign m_total_bytes = m_total_bytes_reg;
    assign m_last        = m_last_reg;

endmodule
`default_nettype wire
